[hw/rtl/obl_pkg.sv]
package obl_pkg;

  localparam int FUNC_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [FUNC_W-1:0] FN_APPEND    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH      = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_AFTER = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_VALUE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_LAST  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FN_DUMP      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_INS  = 2'd1;
  localparam cell_op_t OP_DEL  = 2'd2;
  localparam cell_op_t OP_ROT  = 2'd3;

  typedef logic [2:0] trig_t;
  localparam trig_t TRG_COUNT    = 3'd0;
  localparam trig_t TRG_HEAD     = 3'd1;
  localparam trig_t TRG_KEY_LEFT = 3'd2;
  localparam trig_t TRG_VALUE    = 3'd3;
  localparam trig_t TRG_TAIL     = 3'd4;

  typedef struct packed {
    cell_op_t          op;
    trig_t             trig;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] key;
    logic [BYTE_W-1:0] head;
  } obl_ctl_t;

endpackage

[hw/rtl/obl_if.sv]
interface obl_in_if import obl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] value;
  logic [BYTE_W-1:0] key;

  modport source (output valid, output func, output value, output key, input ready);
  modport sink   (input valid, input func, input value, input key, output ready);
endinterface

interface obl_out_if import obl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;
  logic [BYTE_W-1:0]   item;
  logic                item_valid;
  logic                last;

  modport source (output valid, output status, output count, output item,
                  output item_valid, output last, input ready);
  modport sink   (input valid, input status, input count, input item,
                  input item_valid, input last, output ready);
endinterface

[hw/rtl/obl_cell.sv]
module obl_cell
  import obl_pkg::*;
#(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  obl_ctl_t          ctl,
  input  logic [CW-1:0]     count,
  input  logic [BYTE_W-1:0] left_data,
  input  logic [BYTE_W-1:0] right_data,
  input  logic              chain_in,
  output logic              chain_out,
  output logic [BYTE_W-1:0] data_out
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_N  = CW'(IDX + 1);
  localparam logic [CW-1:0] IDX_P  = CW'((IDX > 0) ? IDX - 1 : 0);
  localparam logic          HAS_L  = (IDX > 0);

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] data_nxt;
  logic              own_valid;
  logic              left_valid;
  logic              hit;
  logic              mark;

  assign own_valid  = (IDX_C < count);
  assign left_valid = HAS_L && (IDX_P < count);

  always_comb begin
    case (ctl.trig)
      TRG_COUNT:    hit = (IDX_C == count);
      TRG_HEAD:     hit = (IDX == 0);
      TRG_KEY_LEFT: hit = left_valid && (left_data == ctl.key);
      TRG_VALUE:    hit = own_valid && (data_r == ctl.value);
      TRG_TAIL:     hit = own_valid && (IDX_N == count);
      default:      hit = 1'b0;
    endcase
  end

  assign mark      = chain_in | hit;
  assign chain_out = mark;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INS: begin
        if (chain_in) begin
          data_nxt = left_data;
        end else if (hit) begin
          data_nxt = ctl.value;
        end
      end
      OP_DEL: begin
        if (mark) begin
          data_nxt = right_data;
        end
      end
      OP_ROT: begin
        data_nxt = (IDX_N == count) ? ctl.head : right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

[hw/rtl/ordered_byte_list_engine_unit.sv]
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    func[2:0] value[7:0] key[7:0]
// out_ch   out  valid/ready    status[1:0] count[4:0] item[7:0] item_valid last
//
// In an edit, every cell compares and shifts at once, a first-match flag
// ripples down the row of cells, and the result lands in the output
// register. A dump of N entries gives N results once the request is taken,
// one result per cycle while the output is not stalled, rotating the row
// through its head; an empty dump gives one result.
// rst_n (synchronous, active low) clears the count, state and output valid.
// Input is taken only when no dump runs and the output register is free
// or being drained; a stalled output holds everything.
module ordered_byte_list_engine_unit
  import obl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  obl_in_if.sink    in_ch,
  obl_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic              state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     cursor_r, cursor_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CW-1:0]       out_count_r;
  logic [BYTE_W-1:0]   out_item_r;
  logic                out_item_valid_r;
  logic                out_last_r;

  obl_ctl_t          ctl;
  logic [CAPACITY:0] chain;
  logic [BYTE_W-1:0] cell_data [CAPACITY];

  logic out_free, in_acc, edit_go, dump_empty, dump_start, dump_step, dump_last;
  logic full, empty, found;
  logic [STATUS_W-1:0] edit_status;
  logic [CW+COUNT_W-1:0] count_ext;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign full     = (count_r == CAP_C);
  assign empty    = (count_r == '0);
  assign found    = chain[CAPACITY];

  assign edit_go    = in_acc && (in_ch.func != FN_DUMP);
  assign dump_empty = in_acc && (in_ch.func == FN_DUMP) && empty;
  assign dump_start = in_acc && (in_ch.func == FN_DUMP) && !empty;
  assign dump_step  = (state_r == S_DUMP) && out_free;
  assign dump_last  = (cursor_r + ONE_C == count_r);

  always_comb begin
    ctl.op    = OP_HOLD;
    ctl.trig  = TRG_HEAD;
    ctl.value = in_ch.value;
    ctl.key   = in_ch.key;
    ctl.head  = cell_data[0];
    if (dump_step) begin
      ctl.op = OP_ROT;
    end else if (edit_go) begin
      case (in_ch.func)
        FN_APPEND: begin
          ctl.trig = TRG_COUNT;
          ctl.op   = full ? OP_HOLD : OP_INS;
        end
        FN_PUSH: begin
          ctl.trig = TRG_HEAD;
          ctl.op   = full ? OP_HOLD : OP_INS;
        end
        FN_INS_AFTER: begin
          ctl.trig = TRG_KEY_LEFT;
          ctl.op   = full ? OP_HOLD : OP_INS;
        end
        FN_DEL_VALUE: begin
          ctl.trig = TRG_VALUE;
          ctl.op   = empty ? OP_HOLD : OP_DEL;
        end
        FN_DEL_LAST: begin
          ctl.trig = TRG_TAIL;
          ctl.op   = empty ? OP_HOLD : OP_DEL;
        end
        FN_DEL_FIRST: begin
          ctl.trig = TRG_HEAD;
          ctl.op   = empty ? OP_HOLD : OP_DEL;
        end
        default: ctl.op = OP_HOLD;
      endcase
    end
  end

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [BYTE_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    obl_cell #(.CW(CW), .IDX(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .left_data  (left_d),
      .right_data (right_d),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .data_out   (cell_data[i])
    );
  end

  always_comb begin
    edit_status = ST_OK;
    count_nxt   = count_r;
    case (in_ch.func)
      FN_APPEND, FN_PUSH, FN_INS_AFTER: begin
        if (full) begin
          edit_status = ST_FULL;
        end else if (!found) begin
          edit_status = ST_NOT_FOUND;
        end else if (edit_go) begin
          count_nxt = count_r + ONE_C;
        end
      end
      FN_DEL_VALUE, FN_DEL_LAST, FN_DEL_FIRST: begin
        if (empty) begin
          edit_status = ST_EMPTY;
        end else if (!found) begin
          edit_status = ST_NOT_FOUND;
        end else if (edit_go) begin
          count_nxt = count_r - ONE_C;
        end
      end
      default: edit_status = ST_OK;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    if (dump_start) begin
      state_nxt  = S_DUMP;
      cursor_nxt = '0;
    end else if (dump_step) begin
      cursor_nxt = cursor_r + ONE_C;
      if (dump_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      if (edit_go || dump_empty || dump_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dump_step) begin
      out_status_r     <= ST_OK;
      out_count_r      <= count_r;
      out_item_r       <= cell_data[0];
      out_item_valid_r <= 1'b1;
      out_last_r       <= dump_last;
    end else if (dump_empty) begin
      out_status_r     <= ST_EMPTY;
      out_count_r      <= count_r;
      out_item_r       <= '0;
      out_item_valid_r <= 1'b0;
      out_last_r       <= 1'b1;
    end else if (edit_go) begin
      out_status_r     <= edit_status;
      out_count_r      <= count_nxt;
      out_item_r       <= '0;
      out_item_valid_r <= 1'b0;
      out_last_r       <= 1'b1;
    end
  end

  assign count_ext         = {{COUNT_W{1'b0}}, out_count_r};
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.count      = count_ext[COUNT_W-1:0];
  assign out_ch.item       = out_item_r;
  assign out_ch.item_valid = out_item_valid_r;
  assign out_ch.last       = out_last_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("entry count above capacity");

  a_edit_result : assert property (@(posedge clk) disable iff (!rst_n)
    edit_go |=> out_valid_r && out_last_r)
    else $error("edit gave no final result");

  a_dump_count_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |=> $stable(count_r))
    else $error("count moved during dump");

  a_dump_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> !in_ch.ready)
    else $error("input taken during dump");

endmodule

[verif/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import obl_pkg::*;

  localparam int LIST_CAP = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED = 100;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [BYTE_W-1:0]   item;
    logic                item_valid;
    logic                last;
  } list_result_t;

  class list_scoreboard;
    logic [BYTE_W-1:0] cells [LIST_CAP];
    int unsigned depth;
    list_result_t awaited [$];

    function int unsigned pending();
      return awaited.size();
    endfunction

    function logic [BYTE_W-1:0] pick_entry();
      if (depth == 0) return BYTE_W'($urandom);
      return cells[$urandom_range(depth - 1)];
    endfunction

    function int unsigned locate(logic [BYTE_W-1:0] b);
      for (int unsigned i = 0; i < depth; i++) begin
        if (cells[i] == b) return i;
      end
      return depth;
    endfunction

    function void place_at(int unsigned pos, logic [BYTE_W-1:0] b);
      for (int unsigned i = depth; i > pos; i--) begin
        cells[i] = cells[i - 1];
      end
      cells[pos] = b;
      depth++;
    endfunction

    function void drop_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < depth; i++) begin
        cells[i] = cells[i + 1];
      end
      depth--;
    endfunction

    function void note_item(logic [FUNC_W-1:0] f, logic [BYTE_W-1:0] v,
                            logic [BYTE_W-1:0] k);
      logic [STATUS_W-1:0] st;
      int unsigned pos;
      list_result_t r;
      st = ST_OK;
      case (f)
        FN_APPEND, FN_PUSH: begin
          if (depth >= LIST_CAP) st = ST_FULL;
          else place_at((f == FN_APPEND) ? depth : 0, v);
        end
        FN_INS_AFTER: begin
          if (depth >= LIST_CAP) begin
            st = ST_FULL;
          end else begin
            pos = locate(k);
            if (pos >= depth) st = ST_NOT_FOUND;
            else place_at(pos + 1, v);
          end
        end
        FN_DEL_VALUE: begin
          if (depth == 0) begin
            st = ST_EMPTY;
          end else begin
            pos = locate(v);
            if (pos >= depth) st = ST_NOT_FOUND;
            else drop_at(pos);
          end
        end
        FN_DEL_LAST, FN_DEL_FIRST: begin
          if (depth == 0) st = ST_EMPTY;
          else drop_at((f == FN_DEL_LAST) ? depth - 1 : 0);
        end
        FN_DUMP: begin
          if (depth == 0) begin
            st = ST_EMPTY;
          end else begin
            for (int unsigned i = 0; i < depth; i++) begin
              r.status = ST_OK;
              r.count = COUNT_W'(depth);
              r.item = cells[i];
              r.item_valid = 1'b1;
              r.last = (i + 1 == depth);
              awaited.push_back(r);
            end
            return;
          end
        end
        default: ;
      endcase
      r.status = st;
      r.count = COUNT_W'(depth);
      r.item = '0;
      r.item_valid = 1'b0;
      r.last = 1'b1;
      awaited.push_back(r);
    endfunction

    function string check_result(list_result_t got);
      list_result_t want;
      string why;
      if (awaited.size() == 0)
        return $sformatf(" unexpected result status=%0d count=%0d item=%02h",
                         got.status, got.count, got.item);
      want = awaited.pop_front();
      why = "";
      if (got.status !== want.status)
        why = {why, $sformatf(" status %0d want %0d", got.status, want.status)};
      if (got.count !== want.count)
        why = {why, $sformatf(" count %0d want %0d", got.count, want.count)};
      if (got.item !== want.item)
        why = {why, $sformatf(" item %02h want %02h", got.item, want.item)};
      if (got.item_valid !== want.item_valid)
        why = {why, $sformatf(" item_valid %0b want %0b", got.item_valid,
                              want.item_valid)};
      if (got.last !== want.last)
        why = {why, $sformatf(" last %0b want %0b", got.last, want.last)};
      return why;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int error_count = 0;
  int quiet_cycles = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  list_scoreboard board = new();

  obl_in_if in_ch ();
  obl_out_if out_ch ();

  ordered_byte_list_engine_unit #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  task automatic report(input string why);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("mismatch at %0t:%s", $time, why);
  endtask

  always @(posedge clk) begin : take_results
    list_result_t got;
    string why;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.count = out_ch.count;
      got.item = out_ch.item;
      got.item_valid = out_ch.item_valid;
      got.last = out_ch.last;
      why = board.check_result(got);
      if (why != "") report(why);
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] any_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return BYTE_W'($urandom_range(3));
    if (roll < 40) return 8'hFF;
    return BYTE_W'($urandom);
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] v,
                           input logic [BYTE_W-1:0] k);
    if ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.value <= v;
    in_ch.key <= k;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(f, v, k);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic random_burst(input int unsigned n);
    bit filling;
    bit grow;
    int unsigned roll;
    logic [BYTE_W-1:0] v;
    filling = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      if (board.depth >= LIST_CAP && $urandom_range(2) == 0) filling = 1'b0;
      else if (board.depth == 0 && $urandom_range(2) == 0) filling = 1'b1;
      roll = $urandom_range(99);
      v = any_byte();
      if (roll < 8) begin
        send_item(FN_DUMP, v, any_byte());
      end else if (roll < 12) begin
        send_item(FUNC_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      end else begin
        roll = $urandom_range(99);
        grow = filling ? (roll < 85) : (roll >= 85);
        if (grow) begin
          case ($urandom_range(2))
            0: send_item(FN_APPEND, v, any_byte());
            1: send_item(FN_PUSH, v, any_byte());
            default: send_item(FN_INS_AFTER, v,
                               ($urandom_range(4) == 0) ? any_byte() : board.pick_entry());
          endcase
        end else begin
          case ($urandom_range(2))
            0: send_item(FN_DEL_VALUE,
                         ($urandom_range(4) == 0) ? v : board.pick_entry(), any_byte());
            1: send_item(FN_DEL_LAST, v, any_byte());
            default: send_item(FN_DEL_FIRST, v, any_byte());
          endcase
        end
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_APPEND;
    in_ch.value = '0;
    in_ch.key = '0;
    out_ch.ready = 1'b0;
    board.depth = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_item(FN_DUMP, 8'h00, 8'h00);
    send_item(FN_DEL_VALUE, 8'h00, 8'hFF);
    send_item(FN_DEL_LAST, 8'hFF, 8'h00);
    send_item(FN_DEL_FIRST, 8'h55, 8'hAA);
    send_item(FN_UNUSED, 8'hFF, 8'hFF);
    send_item(FN_APPEND, 8'h00, 8'hFF);
    send_item(FN_APPEND, 8'hFF, 8'h00);
    send_item(FN_PUSH, 8'hA5, 8'h5A);
    send_item(FN_APPEND, 8'hFF, 8'h11);
    send_item(FN_INS_AFTER, 8'h5A, 8'hFF);
    send_item(FN_INS_AFTER, 8'h42, 8'h33);
    send_item(FN_DEL_VALUE, 8'h77, 8'h00);
    send_item(FN_UNUSED, 8'h00, 8'h00);
    send_item(FN_DUMP, 8'hFF, 8'hFF);
    send_item(FN_DEL_VALUE, 8'hFF, 8'h00);
    send_item(FN_DEL_LAST, 8'h00, 8'h00);
    send_item(FN_DEL_FIRST, 8'h00, 8'h00);
    send_item(FN_DUMP, 8'h00, 8'h00);
    random_burst(16);
    drain();

    in_idle_pct = 78;
    out_stall_pct = 0;
    random_burst(32);
    drain();

    in_idle_pct = 0;
    out_stall_pct = 78;
    random_burst(32);
    drain();

    in_idle_pct = 6;
    out_stall_pct = 6;
    random_burst(32);
    drain();

    repeat (20) @(posedge clk);
    if (error_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
